### rtl/core/bfs_pkg.sv
// Shared types and constants for the breadth-first search block.
// Holds field widths, register indexes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bfs_pkg;

   localparam int DEF_MAX_NODES = 64;
   localparam int NODE_FIELD_W  = 6;
   localparam int ROW_FIELD_W   = 64;
   localparam int COUNT_W       = 7;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [COUNT_W-1:0]      NODE_COUNT_RST = 7'd64;
   localparam logic [NODE_FIELD_W-1:0] START_NODE_RST = 6'd0;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   typedef enum logic {
      REG_NODE_COUNT = 1'b0,
      REG_START_NODE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQ,
      ST_FETCH,
      ST_ROW,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic deq;
      logic fetch;
      logic row;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic pending_any;
      logic queue_empty;
      logic rsp_busy;
   } status_type;

endpackage

### rtl/core/bfs_ctrl.sv
// Controller state machine for the breadth-first search block.
// Sequences dequeue, row fetch, neighbor scan and emit; depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_ctrl
   import bfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_mode,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_mode == MODE_RUN) begin
                  cmd.start = 1'b1;
                  state_in  = ST_DEQ;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_DEQ: begin
            cmd.deq  = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_ROW;
         end
         ST_ROW: begin
            cmd.row  = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // enqueue one new neighbor per cycle until none is left
            if (status.pending_any) begin
               cmd.scan = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register has room
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = status.queue_empty ? ST_IDLE : ST_DEQ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/bfs_dpath.sv
// Datapath for the breadth-first search block: adjacency memory, visit queue memory,
// discovered marks, pending neighbor mask and the result register; depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_dpath
   import bfs_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
)(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic [NODE_FIELD_W-1:0] load_index,
   input  logic [ROW_FIELD_W-1:0]  load_row,
   input  logic [COUNT_W-1:0]      node_count,
   input  logic [NODE_FIELD_W-1:0] start_node,
   input  logic                    rsp_tready,
   output status_type              status,
   output logic                    rsp_tvalid,
   output logic [NODE_FIELD_W-1:0] rsp_node,
   output logic                    rsp_last
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);

   function automatic logic [NODE_W-1:0] encode(input logic [MAX_NODES-1:0] onehot);
      logic [NODE_W-1:0] idx;
      idx = '0;
      for (int j = 0; j < MAX_NODES; j++) begin
         if (onehot[j]) idx = idx | NODE_W'(j);
      end
      return idx;
   endfunction

   logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
   logic [NODE_W-1:0]    q_mem   [MAX_NODES];

   logic [MAX_NODES-1:0] adj_rdata_ff;
   logic [NODE_W-1:0]    q_rdata_ff;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     tail_ff, tail_in;
   logic [MAX_NODES-1:0] disc_ff, disc_in;
   logic [MAX_NODES-1:0] keep_ff, keep_in;
   logic [MAX_NODES-1:0] pending_ff, pending_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_FIELD_W-1:0] rsp_node_ff, rsp_node_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]   count;
   logic [NODE_W-1:0]    start_idx;
   logic [MAX_NODES-1:0] lowest;
   logic [NODE_W-1:0]    scan_idx;
   logic                 load_ok;
   logic                 q_we;
   logic [NODE_W-1:0]    q_waddr;
   logic [NODE_W-1:0]    q_wdata;

   // clamp node count into 1..MAX_NODES
   always_comb begin
      if (node_count == '0) begin
         count = COUNT_W'(1);
      end else if (node_count > COUNT_W'(MAX_NODES)) begin
         count = COUNT_W'(MAX_NODES);
      end else begin
         count = node_count;
      end
      for (int j = 0; j < MAX_NODES; j++) begin
         keep_in[j] = COUNT_W'(j) < count;
      end
      start_idx = ({1'b0, start_node} < count) ? start_node[NODE_W-1:0] : '0;
   end

   assign lowest   = pending_ff & (~pending_ff + MAX_NODES'(1));
   assign scan_idx = encode(lowest);
   assign load_ok  = {1'b0, load_index} < COUNT_W'(MAX_NODES);
   assign q_we     = cmd.start | cmd.scan;
   assign q_waddr  = cmd.start ? '0 : tail_ff[NODE_W-1:0];
   assign q_wdata  = cmd.start ? start_idx : scan_idx;

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         adj_mem[load_index[NODE_W-1:0]] <= load_row[MAX_NODES-1:0];
      end
      if (cmd.fetch) begin
         adj_rdata_ff <= adj_mem[q_rdata_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      if (cmd.deq) begin
         q_rdata_ff <= q_mem[head_ff[NODE_W-1:0]];
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      disc_in      = disc_ff;
      pending_in   = pending_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.start) begin
         disc_in            = '0;
         disc_in[start_idx] = 1'b1;
         head_in            = '0;
         tail_in            = CNT_W'(1);
      end
      if (cmd.deq) begin
         head_in = head_ff + CNT_W'(1);
      end
      if (cmd.fetch) begin
         node_in = q_rdata_ff;
      end
      if (cmd.row) begin
         pending_in = adj_rdata_ff & keep_ff & ~disc_ff;
      end
      if (cmd.scan) begin
         disc_in    = disc_ff | lowest;
         pending_in = pending_ff & ~lowest;
         tail_in    = tail_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_node_in  = NODE_FIELD_W'(node_ff);
         rsp_last_in  = head_ff == tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         disc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         keep_ff <= keep_in;
      end
      pending_ff  <= pending_in;
      node_ff     <= node_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.pending_any = |pending_ff;
   assign status.queue_empty = head_ff == tail_ff;
   assign status.rsp_busy    = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### rtl/core/bfs_adjacency_matrix.sv
// Breadth-first search over an adjacency matrix.
// A run request steps each visited node through dequeue, row fetch, row and scan states,
// enqueuing one newly discovered neighbor per scan cycle, with registered memory reads,
// then emits it, waiting while a result sits in the output register for rsp_tready;
// the first result is the start node, emitted after its neighbors are enqueued.
// Synchronous reset clears control state, node_count to 64 and start_node to 0;
// adjacency rows are undefined until loaded.
`timescale 1ns / 1ps

module bfs_adjacency_matrix
   import bfs_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // row_index[5:0], row_bits[69:6], zero pad
   input  logic                   req_tuser,   // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // visited_node[5:0], zero pad
   output logic                   rsp_tlast,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [COUNT_W-1:0]      node_count_ff, node_count_in;
   logic [NODE_FIELD_W-1:0] start_node_ff, start_node_in;
   logic                    csr_write;
   reg_index_type           csr_index;
   cmd_type                 cmd;
   status_type              status;
   logic [NODE_FIELD_W-1:0] rsp_node;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      node_count_in = node_count_ff;
      start_node_in = start_node_ff;
      csr_prdata    = '0;
      case (csr_index)
         REG_NODE_COUNT: begin
            csr_prdata = CSR_DATA_W'(node_count_ff);
            if (csr_write) node_count_in = csr_pwdata[COUNT_W-1:0];
         end
         REG_START_NODE: begin
            csr_prdata = CSR_DATA_W'(start_node_ff);
            if (csr_write) start_node_in = csr_pwdata[NODE_FIELD_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         start_node_ff <= START_NODE_RST;
      end else begin
         node_count_ff <= node_count_in;
         start_node_ff <= start_node_in;
      end
   end

   bfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bfs_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_index (req_tdata[NODE_FIELD_W-1:0]),
      .load_row   (req_tdata[NODE_FIELD_W +: ROW_FIELD_W]),
      .node_count (node_count_ff),
      .start_node (start_node_ff),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_node   (rsp_node),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_node);

endmodule
